// File: design/bdq_pkg.sv
// Shared sizes, codes and state encoding for the bounded deque with remove.
package bdq_pkg;

	localparam int DEPTH     = 16;
	localparam int ITEM_W    = 32;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);

	localparam int OP_W      = 3;
	localparam int TAG_IN_W  = 32;
	localparam int STAT_W    = 2;
	localparam int LEN_W     = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_BACK  = 3'd5,
		OP_REMOVE     = 3'd6,
		OP_UNUSED     = 3'd7
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_FIN
	} state_t;

endpackage

// File: design/bdq_req_if.sv
// Request channel of the deque: operation code and item tag with valid/ready.
interface bdq_req_if;
	import bdq_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [TAG_IN_W-1:0] item;

	modport source (output valid, output operation, output item, input ready);
	modport sink   (input valid, input operation, input item, output ready);
endinterface

// File: design/bdq_rsp_if.sv
// Response channel of the deque: returned tag, status and length with valid/ready.
interface bdq_rsp_if;
	import bdq_pkg::*;

	logic                valid;
	logic                ready;
	logic [TAG_IN_W-1:0] item_out;
	logic [STAT_W-1:0]   status;
	logic [LEN_W-1:0]    length;

	modport source (output valid, output item_out, output status, output length, input ready);
	modport sink   (input valid, input item_out, input status, input length, output ready);
endinterface

// File: design/bounded_deque_with_remove.sv
// Bounded deque with remove: one request word in, one response word out per request.
// Push and the unused code go from execute to finish; pops and peeks of a non-empty queue pass
// a read state first; remove, bound by its one memory port, scans with a read and a compare
// state per entry and on a match moves later entries up with a read and a write state each.
// One request is in flight at a time; the next is accepted once the response is registered.
// Reset (arst_n low) empties the queue and drops any pending response; storage is not cleared.
module bounded_deque_with_remove (
	input  logic       clk,
	input  logic       arst_n,
	bdq_req_if.sink    req,
	bdq_rsp_if.source  rsp
);
	import bdq_pkg::*;

	// Control state.
	state_t              state_q, state_nxt;
	op_t                 op_q;
	logic [ITEM_W-1:0]   tag_q;
	logic [IDX_W-1:0]    head_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    off_q;

	// Staged result, moved into the output register in the finish state.
	logic [ITEM_W-1:0]   res_item_q;
	status_t             res_stat_q;

	// Output register.
	logic                out_valid_q;
	logic [TAG_IN_W-1:0] out_item_q;
	logic [STAT_W-1:0]   out_stat_q;
	logic [LEN_W-1:0]    out_len_q;

	// Ring storage, a single-port memory with registered read data.
	logic [ITEM_W-1:0]   mem_q [DEPTH];
	logic [ITEM_W-1:0]   rd_q;

	// Sequencer controls.
	logic [CNT_W-1:0]    mem_off;
	logic [IDX_W-1:0]    mem_addr;
	logic                mem_we;
	logic [ITEM_W-1:0]   mem_wdata;
	logic                head_ld;
	logic                cnt_inc;
	logic                cnt_dec;
	logic                off_clr;
	logic                off_inc;
	logic                res_ld;
	logic [ITEM_W-1:0]   res_item;
	status_t             res_stat;
	logic                out_ld;

	logic                full;
	logic                empty;
	logic                out_free;
	logic                match;
	logic                last_off;
	logic [CNT_W-1:0]    off_nx;
	logic                accept;

	// Ring position of the entry at a logical offset from the head. This adder is the one
	// address unit that every memory access and head move goes through.
	function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] head,
		input logic [CNT_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, head} + {1'b0, off[IDX_W-1:0]};
		if (sum >= (IDX_W+1)'(DEPTH)) begin
			sum = sum - (IDX_W+1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign out_free = !out_valid_q || rsp.ready;
	assign match    = (rd_q == tag_q);
	assign off_nx   = off_q + CNT_W'(1);
	assign last_off = (off_nx >= count_q);
	assign mem_addr = ring_pos(head_q, mem_off);
	assign accept   = req.valid && req.ready;

	assign req.ready    = (state_q == S_IDLE);
	assign rsp.valid    = out_valid_q;
	assign rsp.item_out = out_item_q;
	assign rsp.status   = out_stat_q;
	assign rsp.length   = out_len_q;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
						state_nxt = empty ? S_FIN : S_READ;
					end
					OP_REMOVE: begin
						state_nxt = empty ? S_FIN : S_SCAN_RD;
					end
					default: begin
						state_nxt = S_FIN;
					end
				endcase
			end
			S_READ: begin
				state_nxt = S_FIN;
			end
			S_SCAN_RD: begin
				state_nxt = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (match) begin
					state_nxt = S_SHIFT_RD;
				end else if (last_off) begin
					state_nxt = S_FIN;
				end else begin
					state_nxt = S_SCAN_RD;
				end
			end
			S_SHIFT_RD: begin
				state_nxt = last_off ? S_FIN : S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				state_nxt = S_SHIFT_RD;
			end
			S_FIN: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		mem_off   = '0;
		mem_we    = 1'b0;
		mem_wdata = tag_q;
		head_ld   = 1'b0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		off_clr   = 1'b0;
		off_inc   = 1'b0;
		res_ld    = 1'b0;
		res_item  = '0;
		res_stat  = STAT_OK;
		out_ld    = 1'b0;
		case (state_q)
			S_EXEC: begin
				case (op_q)
					OP_PUSH_FRONT: begin
						res_ld = 1'b1;
						if (full) begin
							res_stat = STAT_FULL;
						end else begin
							// One step back from the head is offset DEPTH-1 around the ring.
							mem_off = CNT_W'(DEPTH - 1);
							mem_we  = 1'b1;
							head_ld = 1'b1;
							cnt_inc = 1'b1;
						end
					end
					OP_PUSH_BACK: begin
						res_ld = 1'b1;
						if (full) begin
							res_stat = STAT_FULL;
						end else begin
							mem_off = count_q;
							mem_we  = 1'b1;
							cnt_inc = 1'b1;
						end
					end
					OP_POP_FRONT, OP_PEEK_FRONT: begin
						if (empty) begin
							res_ld   = 1'b1;
							res_stat = STAT_EMPTY;
						end
					end
					OP_POP_BACK, OP_PEEK_BACK: begin
						if (empty) begin
							res_ld   = 1'b1;
							res_stat = STAT_EMPTY;
						end else begin
							mem_off = count_q - CNT_W'(1);
						end
					end
					OP_REMOVE: begin
						off_clr = 1'b1;
						if (empty) begin
							res_ld   = 1'b1;
							res_stat = STAT_NOT_FOUND;
						end
					end
					default: begin
						res_ld = 1'b1;
					end
				endcase
			end
			S_READ: begin
				res_ld   = 1'b1;
				res_item = rd_q;
				if (op_q == OP_POP_FRONT) begin
					mem_off = CNT_W'(1);
					head_ld = 1'b1;
					cnt_dec = 1'b1;
				end else if (op_q == OP_POP_BACK) begin
					cnt_dec = 1'b1;
				end
			end
			S_SCAN_RD: begin
				mem_off = off_q;
			end
			S_SCAN_CMP: begin
				if (!match) begin
					if (last_off) begin
						res_ld   = 1'b1;
						res_stat = STAT_NOT_FOUND;
					end else begin
						off_inc = 1'b1;
					end
				end
			end
			S_SHIFT_RD: begin
				if (last_off) begin
					cnt_dec = 1'b1;
					res_ld  = 1'b1;
				end else begin
					mem_off = off_nx;
				end
			end
			S_SHIFT_WR: begin
				mem_off   = off_q;
				mem_we    = 1'b1;
				mem_wdata = rd_q;
				off_inc   = 1'b1;
			end
			S_FIN: begin
				out_ld = out_free;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (head_ld) begin
				head_q <= mem_addr;
			end
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(req.operation);
			tag_q <= ITEM_W'(req.item);
		end
		if (off_clr) begin
			off_q <= '0;
		end else if (off_inc) begin
			off_q <= off_nx;
		end
		if (res_ld) begin
			res_item_q <= res_item;
			res_stat_q <= res_stat;
		end
		if (out_ld) begin
			out_item_q <= TAG_IN_W'(res_item_q);
			out_stat_q <= res_stat_q;
			out_len_q  <= LEN_W'(count_q);
		end
	end

	// Ring storage.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wdata;
		end
		rd_q <= mem_q[mem_addr];
	end

endmodule

// File: bench/bdq_tb_pkg.sv
// Scoreboard class for the bounded deque bench: deque predictor and reply checker.
package bdq_tb_pkg;
	import bdq_pkg::*;

	typedef struct packed {
		logic [TAG_IN_W-1:0] item_out;
		status_t             status;
		logic [LEN_W-1:0]    length;
	} deque_reply_t;

	class deque_scoreboard;
		logic [ITEM_W-1:0] ring [DEPTH];
		int                head;
		int                count;
		deque_reply_t      pending_replies [$];
		int                errors;
		int                requests_seen;
		int                full_drops;
		int                empty_hits;
		int                removes_hit;
		int                removes_missed;

		function new();
			head           = 0;
			count          = 0;
			errors         = 0;
			requests_seen  = 0;
			full_drops     = 0;
			empty_hits     = 0;
			removes_hit    = 0;
			removes_missed = 0;
		endfunction

		function int slot(int offset);
			return (head + offset) % DEPTH;
		endfunction

		function int pending_count();
			return pending_replies.size();
		endfunction

		function int fill_level();
			return count;
		endfunction

		// A tag that is currently held when the queue is not empty, so that removes can hit.
		function logic [TAG_IN_W-1:0] stored_tag();
			if (count == 0) begin
				return $urandom;
			end
			return ring[slot($urandom_range(0, count - 1))];
		endfunction

		// Applies one accepted request to the deque image and queues its reply.
		function void note_request(op_t op, logic [TAG_IN_W-1:0] item);
			deque_reply_t      r;
			logic [ITEM_W-1:0] tag;
			int                hit_pos;
			int                i;
			tag        = item[ITEM_W-1:0];
			r.item_out = '0;
			r.status   = STAT_OK;
			case (op)
				OP_PUSH_FRONT: begin
					if (count >= DEPTH) begin
						r.status = STAT_FULL;
					end else begin
						head       = (head == 0) ? DEPTH - 1 : head - 1;
						ring[head] = tag;
						count++;
					end
				end
				OP_PUSH_BACK: begin
					if (count >= DEPTH) begin
						r.status = STAT_FULL;
					end else begin
						ring[slot(count)] = tag;
						count++;
					end
				end
				OP_POP_FRONT, OP_PEEK_FRONT: begin
					if (count == 0) begin
						r.status = STAT_EMPTY;
					end else begin
						r.item_out = ring[head];
						if (op == OP_POP_FRONT) begin
							head = slot(1);
							count--;
						end
					end
				end
				OP_POP_BACK, OP_PEEK_BACK: begin
					if (count == 0) begin
						r.status = STAT_EMPTY;
					end else begin
						r.item_out = ring[slot(count - 1)];
						if (op == OP_POP_BACK) begin
							count--;
						end
					end
				end
				OP_REMOVE: begin
					hit_pos = -1;
					for (i = 0; i < count && hit_pos < 0; i++) begin
						if (ring[slot(i)] == tag) begin
							hit_pos = i;
						end
					end
					if (hit_pos < 0) begin
						r.status = STAT_NOT_FOUND;
					end else begin
						for (i = hit_pos; i + 1 < count; i++) begin
							ring[slot(i)] = ring[slot(i + 1)];
						end
						count--;
					end
				end
				default: begin
				end
			endcase
			r.length = LEN_W'(count);
			requests_seen++;
			if (r.status == STAT_FULL) full_drops++;
			if (r.status == STAT_EMPTY) empty_hits++;
			if (op == OP_REMOVE && r.status == STAT_OK) removes_hit++;
			if (r.status == STAT_NOT_FOUND) removes_missed++;
			pending_replies.push_back(r);
		endfunction

		function void check_response(logic [TAG_IN_W-1:0] item_out, logic [STAT_W-1:0] status,
				logic [LEN_W-1:0] length);
			deque_reply_t e;
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected reply: item_out %0h status %0d length %0d",
					$time, item_out, status, length);
				errors++;
				return;
			end
			e = pending_replies.pop_front();
			if (item_out !== e.item_out) begin
				$display("%0t: item_out mismatch: expected %0h, actual %0h",
					$time, e.item_out, item_out);
				errors++;
			end
			if (status !== e.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, e.status, status);
				errors++;
			end
			if (length !== e.length) begin
				$display("%0t: length mismatch: expected %0d, actual %0d",
					$time, e.length, length);
				errors++;
			end
		endfunction
	endclass

endpackage

// File: bench/bounded_deque_with_remove_tb.sv
// Top-level bench for the bounded deque with remove: stimulus, handshakes and final verdict.
module bounded_deque_with_remove_tb;
	import bdq_pkg::*;
	import bdq_tb_pkg::*;

	localparam int RANDOM_PER_PHASE = 450;
	// Worst case for one request is a remove that scans and shifts the whole queue.
	localparam int SETTLE_CYCLES    = 4 * DEPTH + 8;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bdq_req_if req ();
	bdq_rsp_if rsp ();

	bounded_deque_with_remove dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	deque_scoreboard sb = new();

	// Percent chance per cycle that the sender holds back a word, and that the
	// receiver refuses one. Both change from phase to phase.
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver decides its ready at the falling edge so that the value is
	// stable well before the rising edge where the handshake is sampled.
	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Every reply word that is taken is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			sb.check_response(rsp.item_out, rsp.status, rsp.length);
		end
	end

	// Drives one request word. It is entered and left at a falling edge. The valid
	// line is only lowered here when the sender decides to idle, so a word that
	// follows directly keeps valid high without a second assignment in one step.
	task automatic send_request(input op_t op, input logic [TAG_IN_W-1:0] item);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid     <= 1'b1;
		req.operation <= op;
		req.item      <= item;
		@(posedge clk);
		while (req.ready !== 1'b1) begin
			@(posedge clk);
		end
		// The word was taken at this edge, so the deque image moves on now; the
		// next random choice then sees the contents that the block holds.
		sb.note_request(op, item);
		@(negedge clk);
	endtask

	// Holds the request side quiet until every predicted reply has been taken.
	// The loop waits on a falling edge before its first check, so valid is never rewritten in one step.
	task automatic wait_for_drain();
		req.valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (sb.pending_count() != 0);
	endtask

	// Tags are mostly drawn from a handful of small values so that duplicates and
	// remove hits are common; the rest are full-width values and the extremes.
	function automatic logic [TAG_IN_W-1:0] pick_tag();
		case ($urandom_range(0, 7))
			0, 1:    return $urandom;
			2:       return '1;
			3:       return '0;
			default: return $urandom_range(0, 7);
		endcase
	endfunction

	// Directed opening: requests on an empty queue, the unused code, both tag
	// extremes, filling to the limit, pushes at both ends on a full queue, a
	// remove of a duplicated tag from the middle, then peeks and pops at both ends.
	task automatic run_directed();
		int i;
		send_request(OP_POP_FRONT, 32'h0);
		send_request(OP_POP_BACK, 32'h0);
		send_request(OP_PEEK_FRONT, 32'h0);
		send_request(OP_REMOVE, 32'h1234_5678);
		send_request(OP_UNUSED, '1);
		send_request(OP_PUSH_FRONT, 32'h0000_0000);
		send_request(OP_PUSH_BACK, 32'hFFFF_FFFF);
		for (i = 0; i < DEPTH - 2; i++) begin
			// Tag pattern repeats every four entries, so remove has duplicates.
			send_request((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, 32'hA5A5_0000 + (i % 4));
		end
		send_request(OP_PUSH_BACK, 32'h5A5A_5A5A);
		send_request(OP_PUSH_FRONT, 32'h5A5A_5A5A);
		send_request(OP_REMOVE, 32'hA5A5_0002);
		send_request(OP_PEEK_FRONT, 32'h0);
		send_request(OP_PEEK_BACK, 32'h0);
		send_request(OP_POP_FRONT, 32'h0);
		send_request(OP_POP_BACK, 32'h0);
	endtask

	// Random requests. The share of pushes among pushes and pops swings between
	// low, even and high every few dozen words, so the queue keeps sweeping from
	// empty to full and back, which exercises wrap-around of the ring at both ends.
	task automatic run_random(input int words);
		int                  n;
		int                  pick;
		int                  push_pct;
		op_t                 op;
		logic [TAG_IN_W-1:0] tag;
		push_pct = 50;
		for (n = 0; n < words; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0:       push_pct = 15;
					1:       push_pct = 50;
					default: push_pct = 85;
				endcase
			end
			pick = $urandom_range(0, 99);
			tag  = pick_tag();
			if (pick < 2) begin
				op = OP_UNUSED;
			end else if (pick < 16) begin
				op = OP_REMOVE;
				if ($urandom_range(0, 99) < 60) begin
					tag = sb.stored_tag();
				end
			end else if (pick < 28) begin
				op = $urandom_range(0, 1) ? OP_PEEK_BACK : OP_PEEK_FRONT;
			end else if ($urandom_range(0, 99) < push_pct) begin
				op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
			end else begin
				op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
			end
			send_request(op, tag);
			// Now and then the sender stops until the block has answered everything.
			if ($urandom_range(0, 99) == 0) begin
				wait_for_drain();
			end
		end
	endtask

	initial begin
		req.valid     = 1'b0;
		req.operation = OP_PUSH_FRONT;
		req.item      = '0;
		rsp.ready     = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// First phase: the sender idles less often than the receiver stalls.
		tx_idle_pct = 23;
		rx_idle_pct = 45;
		run_directed();
		run_random(RANDOM_PER_PHASE);

		// Second phase: the roles swap, so replies are mostly taken at once.
		wait_for_drain();
		tx_idle_pct = 45;
		rx_idle_pct = 23;
		run_random(RANDOM_PER_PHASE);

		// Last phase: words back to back on both sides.
		wait_for_drain();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(RANDOM_PER_PHASE);

		wait_for_drain();
		// Any stray reply word would show up within the longest remove.
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Ran %0d requests: %0d pushes dropped on a full queue, %0d pops or peeks on empty.",
			sb.requests_seen, sb.full_drops, sb.empty_hits);
		$display("Removes that found their tag: %0d, removes that found nothing: %0d.",
			sb.removes_hit, sb.removes_missed);
		if (sb.errors == 0 && sb.pending_count() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
